// ----- hw/rtl/dpf_pkg.sv -----
// shared constants and types for the distinct prime factorizer
`timescale 1ns / 1ps

package dpf_pkg;

    localparam int VALUE_WIDTH_DEF = 31;
    localparam int MAX_RESULTS     = 9;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_EVAL = 5'b00100,
        S_FIN  = 5'b01000,
        S_PUSH = 5'b10000
    } t_state;

endpackage

// ----- hw/rtl/distinct_prime_factorizer_core.sv -----
// top level: trial division factorizer with one shared restoring divider
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+------------------------------------
//  input   | i_valid | o_ready | i_value
//  output  | o_valid | i_ready | o_factor, o_has_factor, o_last
//
// each trial division runs the shared divider over every quotient bit in S_DIV,
// then checks the result in S_EVAL; a 31-bit prime tries divisors up to about 46341
// o_ready is high only while the sequencer is idle; one value at a time
// a result waits in the output register; the sequencer stalls only when it
// must hand over another result while that register is still full
// i_rst_n is synchronous, active low, and clears the control state
`timescale 1ns / 1ps

module distinct_prime_factorizer_core
    import dpf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [VALUE_WIDTH-1:0] o_factor,
    output logic                   o_has_factor,
    output logic                   o_last
);

    localparam int BIT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    t_state                 r_state, n_state;
    t_state                 r_ret, n_ret;
    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_d, n_d;
    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [VALUE_WIDTH-1:0] r_part, n_part;
    logic [BIT_W-1:0]       r_bit, n_bit;
    logic                   r_divout, n_divout;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [VALUE_WIDTH-1:0] r_pend, n_pend;
    logic                   r_pend_v, n_pend_v;
    logic [VALUE_WIDTH-1:0] r_e_factor, n_e_factor;
    logic                   r_e_has, n_e_has;
    logic                   r_e_last, n_e_last;
    logic                   r_ov, n_ov;
    logic [VALUE_WIDTH-1:0] r_of, n_of;
    logic                   r_oh, n_oh;
    logic                   r_ol, n_ol;

    logic [VALUE_WIDTH:0]   w_partial;
    logic [VALUE_WIDTH:0]   w_diff;
    logic                   w_ge;
    logic                   w_slot_free;
    logic                   w_room;

    // restoring divider step: one quotient bit per cycle
    assign w_partial   = {r_part, r_quo[VALUE_WIDTH-1]};
    assign w_diff      = w_partial - {1'b0, r_d};
    assign w_ge        = !w_diff[VALUE_WIDTH];
    assign w_slot_free = !r_ov || i_ready;
    assign w_room      = r_cnt < CNT_W'(MAX_RESULTS);

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_rem      = r_rem;
        n_d        = r_d;
        n_quo      = r_quo;
        n_part     = r_part;
        n_bit      = r_bit;
        n_divout   = r_divout;
        n_cnt      = r_cnt;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_e_factor = r_e_factor;
        n_e_has    = r_e_has;
        n_e_last   = r_e_last;
        n_ov       = r_ov && !i_ready;
        n_of       = r_of;
        n_oh       = r_oh;
        n_ol       = r_ol;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_rem    = i_value;
                    n_d      = VALUE_WIDTH'(2);
                    n_quo    = i_value;
                    n_part   = '0;
                    n_bit    = '0;
                    n_divout = 1'b0;
                    n_cnt    = '0;
                    n_pend_v = 1'b0;
                    if (i_value < VALUE_WIDTH'(2)) begin
                        n_e_factor = '0;
                        n_e_has    = 1'b0;
                        n_e_last   = 1'b1;
                        n_ret      = S_IDLE;
                        n_state    = S_PUSH;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_part = w_ge ? w_diff[VALUE_WIDTH-1:0] : w_partial[VALUE_WIDTH-1:0];
                n_quo  = {r_quo[VALUE_WIDTH-2:0], w_ge};
                n_bit  = r_bit + BIT_W'(1);
                if (r_bit == BIT_W'(VALUE_WIDTH - 1)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_part = '0;
                n_bit  = '0;
                if (!r_divout && (r_quo < r_d)) begin
                    // divisor squared exceeds the remainder
                    n_state = S_FIN;
                end else if (r_part == '0) begin
                    n_rem    = r_quo;
                    n_divout = 1'b1;
                    n_state  = S_DIV;
                    if (!r_divout && w_room) begin
                        n_cnt    = r_cnt + CNT_W'(1);
                        n_pend   = r_d;
                        n_pend_v = 1'b1;
                        if (r_pend_v) begin
                            n_e_factor = r_pend;
                            n_e_has    = 1'b1;
                            n_e_last   = 1'b0;
                            n_ret      = S_DIV;
                            n_state    = S_PUSH;
                        end
                    end
                end else begin
                    // next trial divisor, dividend is the unchanged remainder
                    n_d      = r_d + VALUE_WIDTH'(1);
                    n_quo    = r_rem;
                    n_divout = 1'b0;
                    n_state  = S_DIV;
                end
            end
            S_FIN: begin
                n_e_has = 1'b1;
                n_state = S_PUSH;
                n_ret   = S_IDLE;
                if (r_pend_v) begin
                    n_e_factor = r_pend;
                    n_pend_v   = 1'b0;
                    if ((r_rem > VALUE_WIDTH'(1)) && w_room) begin
                        n_e_last = 1'b0;
                        n_ret    = S_FIN;
                    end else begin
                        n_e_last = 1'b1;
                    end
                end else begin
                    n_e_factor = r_rem;
                    n_e_last   = 1'b1;
                end
            end
            S_PUSH: begin
                if (w_slot_free) begin
                    n_ov    = 1'b1;
                    n_of    = r_e_factor;
                    n_oh    = r_e_has;
                    n_ol    = r_e_last;
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ov     <= 1'b0;
            r_pend_v <= 1'b0;
            r_cnt    <= '0;
            r_divout <= 1'b0;
            r_bit    <= '0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_ov     <= n_ov;
            r_pend_v <= n_pend_v;
            r_cnt    <= n_cnt;
            r_divout <= n_divout;
            r_bit    <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_d        <= n_d;
        r_quo      <= n_quo;
        r_part     <= n_part;
        r_pend     <= n_pend;
        r_e_factor <= n_e_factor;
        r_e_has    <= n_e_has;
        r_e_last   <= n_e_last;
        r_of       <= n_of;
        r_oh       <= n_oh;
        r_ol       <= n_ol;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ov;
    assign o_factor     = r_of;
    assign o_has_factor = r_oh;
    assign o_last       = r_ol;

endmodule

// ----- hw/rtl/dpf_checker.sv -----
// port-level checks for the distinct prime factorizer, bound to the top level
`timescale 1ns / 1ps

module dpf_checker
    import dpf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_ready,
    input logic [VALUE_WIDTH-1:0] i_value,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [VALUE_WIDTH-1:0] o_factor,
    input logic                   o_has_factor,
    input logic                   o_last
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_factor) && $stable(o_last)
            && $stable(o_has_factor))
        else $error("stalled result changed");

    // the no-factor result is the only and final one
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_factor |-> o_last && (o_factor == '0))
        else $error("no-factor result malformed");

    a_factor_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_factor |-> (o_factor >= VALUE_WIDTH'(2)))
        else $error("factor below two");

    // one value at a time: busy right after taking a transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after accept");

    // a value that is not below two brings up no new no-factor result right after it is taken
    a_none_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_value >= VALUE_WIDTH'(2)) |=> !(o_valid && !o_has_factor
            && !$past(o_valid)))
        else $error("no-factor result for a value of two or more");

endmodule

bind distinct_prime_factorizer_core dpf_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_dpf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_value      (i_value),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_factor     (o_factor),
    .o_has_factor (o_has_factor),
    .o_last       (o_last)
);
